// ===== rtl/core/scpd_pkg.sv =====
// Package for the servo command packet deframer.
// Frame constants, the servo letter table and the result record type.
// No dependencies.
package scpd_pkg;

   localparam logic [7:0] START_BYTE     = 8'hAA;
   localparam logic [3:0] CHECK_POS      = 4'd11;
   localparam logic [7:0] FLAG_ACTIVE    = 8'h01;
   localparam logic [7:0] FLAG_DIRECTION = 8'h02;
   localparam int         SERVO_NUM      = 5;
   localparam logic [2:0] LAST_SERVO     = 3'd4;

   localparam logic RESULT_COMMAND = 1'b0;
   localparam logic RESULT_BAD     = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [SERVO_NUM-1:0] active;
      logic [SERVO_NUM-1:0] direction;
   } result_type;

   function automatic logic [7:0] servo_letter(input logic [2:0] servo);
      logic [7:0] letter;
      case (servo)
         3'd0:    letter = 8'h42;
         3'd1:    letter = 8'h53;
         3'd2:    letter = 8'h46;
         3'd3:    letter = 8'h57;
         default: letter = 8'h47;
      endcase
      return letter;
   endfunction

endpackage

// ===== rtl/core/servo_command_packet_deframer.sv =====
// Servo command packet deframer, top level.
// Depends on scpd_pkg for frame constants, the letter table and the result record.
//
// Takes one received byte per cycle while req_ready is high and hunts for the
// start byte 0xAA; a 12-byte frame (start, five letter/flags pairs in the order
// B,S,F,W,G, XOR check) yields one result on its check byte: a command with
// active and direction masks, or a bad message with zero masks. A start byte
// anywhere inside a frame restarts it. A result register plus one skid entry sit
// on the output; a result is registered into the skid entry while rsp_ holds one
// the consumer has not taken, so req_ready drops only while both hold results.
module servo_command_packet_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [4:0] rsp_active_mask,
   output logic [4:0] rsp_direction_mask
);

   logic       in_frame_ff, in_frame_in;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] xor_ff, xor_in;
   logic       ids_ok_ff, ids_ok_in;
   logic [4:0] active_ff, active_in;
   logic [4:0] dir_ff, dir_in;

   scpd_pkg::result_type rsp_ff, rsp_in, skid_ff, skid_in, new_result;
   logic rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;

   logic       fire, is_start, emit, take, good;
   logic [3:0] pos_m1;
   logic [2:0] servo;
   logic [4:0] servo_bit;

   assign req_ready = !skid_valid_ff;
   assign fire      = req_valid && req_ready;
   assign is_start  = (req_rx_byte == scpd_pkg::START_BYTE);
   assign emit      = fire && in_frame_ff && !is_start && (pos_ff >= scpd_pkg::CHECK_POS);
   assign take      = rsp_valid_ff && rsp_ready;

   assign pos_m1    = pos_ff - 4'd1;
   assign servo     = (pos_m1[3:1] > scpd_pkg::LAST_SERVO) ? scpd_pkg::LAST_SERVO
                                                           : pos_m1[3:1];
   assign servo_bit = 5'd1 << servo;
   assign good      = (req_rx_byte == xor_ff) && ids_ok_ff;

   always_comb begin
      new_result.kind      = good ? scpd_pkg::RESULT_COMMAND : scpd_pkg::RESULT_BAD;
      new_result.active    = good ? active_ff : 5'd0;
      new_result.direction = good ? dir_ff : 5'd0;
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      ids_ok_in   = ids_ok_ff;
      active_in   = active_ff;
      dir_in      = dir_ff;
      if (fire) begin
         if (is_start) begin
            in_frame_in = 1'b1;
            pos_in      = 4'd1;
            xor_in      = scpd_pkg::START_BYTE;
            ids_ok_in   = 1'b1;
            active_in   = 5'd0;
            dir_in      = 5'd0;
         end else if (in_frame_ff) begin
            if (pos_ff >= scpd_pkg::CHECK_POS) begin
               in_frame_in = 1'b0;
               pos_in      = 4'd0;
               xor_in      = 8'd0;
               ids_ok_in   = 1'b1;
               active_in   = 5'd0;
               dir_in      = 5'd0;
            end else begin
               xor_in = xor_ff ^ req_rx_byte;
               pos_in = pos_ff + 4'd1;
               if (pos_ff[0]) begin
                  if (req_rx_byte != scpd_pkg::servo_letter(servo)) begin
                     ids_ok_in = 1'b0;
                  end
               end else begin
                  if ((req_rx_byte & scpd_pkg::FLAG_ACTIVE) != 8'd0) begin
                     active_in = active_ff | servo_bit;
                  end
                  if ((req_rx_byte & scpd_pkg::FLAG_DIRECTION) != 8'd0) begin
                     dir_in = dir_ff | servo_bit;
                  end
               end
            end
         end
      end
   end

   // advance the output pair: skid refills the result register when it frees
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = new_result;
            rsp_valid_in = emit;
         end
      end else if (emit) begin
         skid_in       = new_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         pos_ff        <= 4'd0;
         xor_ff        <= 8'd0;
         ids_ok_ff     <= 1'b1;
         active_ff     <= 5'd0;
         dir_ff        <= 5'd0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         pos_ff        <= pos_in;
         xor_ff        <= xor_in;
         ids_ok_ff     <= ids_ok_in;
         active_ff     <= active_in;
         dir_ff        <= dir_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_ff.kind;
   assign rsp_active_mask    = rsp_ff.active;
   assign rsp_direction_mask = rsp_ff.direction;

`ifndef ASSERT_OFF
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a result in front");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (pos_ff >= 4'd1 && pos_ff <= scpd_pkg::CHECK_POS))
      else $error("frame position out of range");

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (fire && is_start) |=> (in_frame_ff && pos_ff == 4'd1))
      else $error("start byte did not open a frame");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == scpd_pkg::RESULT_BAD) |->
         (rsp_ff.active == 5'd0 && rsp_ff.direction == 5'd0))
      else $error("bad message carries nonzero masks");

   a_emit_closes: assert property (@(posedge clock) disable iff (reset)
      emit |=> (!in_frame_ff && rsp_valid_ff))
      else $error("check byte did not close the frame with a result");
`endif

endmodule
